@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the array table engine.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/iate_pkg.sv @@
// Shared types and constants of the indexed array table engine.
// No dependencies; imported by the engine top level, the sequencer, the checker and the testbench.
`default_nettype none

package iate_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int REQ_W  = 3;
	localparam int POS_W  = 5;
	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;
	localparam int ST_W   = 2;
	localparam int IDX_W  = 4;
	localparam int ENT_W  = 5;

	// Width in which positions, counts and the bound are compared.
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	// Signed width of the binary search bounds; holds lo + hi and -1.
	localparam int SRCH_W = CNT_W + 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND  = 3'd0,
		REQ_INSERT  = 3'd1,
		REQ_DELETE  = 3'd2,
		REQ_READ    = 3'd3,
		REQ_LSEARCH = 3'd4,
		REQ_BSEARCH = 3'd5
	} req_type_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         count;
	} res_t;

endpackage

`default_nettype wire

@@ sv/indexed_array_table_engine.sv @@
// Appends, unused codes, rejected requests and inserts or deletes that move no entries
// are settled in the idle state; a read waits on the registered RAM read; insert and
// delete shift entries, insert then writing the new value; binary search reads one
// probe at a time. One item is in work at a time; the entry RAM's single read port
// sets the walk rate. The next item is taken the cycle after a result moves to the
// output register. Reset clears the count and sets capacity to 16; entries are kept.
`default_nettype none

module indexed_array_table_engine (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [iate_pkg::CAP_W-1:0]          cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [iate_pkg::REQ_W-1:0]          req_type,
	input  wire logic [iate_pkg::POS_W-1:0]          position,
	input  wire logic signed [iate_pkg::DATA_W-1:0]  value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [iate_pkg::ST_W-1:0]                status,
	output logic [iate_pkg::IDX_W-1:0]               result_index,
	output logic signed [iate_pkg::DATA_W-1:0]       result_value,
	output logic [iate_pkg::ENT_W-1:0]               entry_count
);
	import iate_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             res_ready;
	logic             out_valid_q;
	res_t             out_q;

	assign req = '{req_type: req_type, position: position, value: value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	iate_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.req_valid(in_valid),
		.req_ready(in_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register frees the sequencer while a result waits downstream.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign result_index = out_q.index;
	assign result_value = out_q.value;
	assign entry_count  = ENT_W'(out_q.count);

endmodule

`default_nettype wire

@@ sv/iate_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the entry store of the array table engine.
`default_nettype none

module iate_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/iate_seq.sv @@
// Request sequencer of the array table engine: decodes one item, walks the
// entry store through iate_ram and holds the result. Depends on iate_pkg and iate_ram.
`default_nettype none

module iate_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [iate_pkg::CAP_W-1:0]  capacity,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire iate_pkg::req_t              req,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output iate_pkg::res_t                   res
);
	import iate_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_PUT   = 7'b0000100,
		S_RWAIT = 7'b0001000,
		S_BREAD = 7'b0010000,
		S_BWAIT = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	req_type_t                 op_q;
	logic [ADDR_W-1:0]         pos_q;
	logic signed [DATA_W-1:0]  val_q;
	logic [ADDR_W-1:0]         rd_addr_q;
	logic [ADDR_W-1:0]         end_addr_q;
	logic                      issue_done_q;
	logic                      vld_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic                      last_s1;
	logic signed [SRCH_W-1:0]  lo_q;
	logic signed [SRCH_W-1:0]  hi_q;
	logic signed [SRCH_W-1:0]  mid_q;
	status_t                   status_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [DATA_W-1:0]  rval_q;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [DATA_W-1:0]         ram_wdata;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [DATA_W-1:0]         ram_rdata;

	req_type_t                 req_op;
	logic [CMP_W-1:0]          pos_x;
	logic [CMP_W-1:0]          count_x;
	logic [CMP_W-1:0]          cap_x;
	logic [CMP_W-1:0]          bound_x;
	logic [ADDR_W-1:0]         pos_a;
	logic [ADDR_W-1:0]         count_a;
	logic [ADDR_W-1:0]         last_a;
	logic                      full;
	logic signed [SRCH_W-1:0]  mid_c;
	logic signed [SRCH_W-1:0]  mid_inc;
	logic signed [SRCH_W-1:0]  mid_dec;
	logic                      req_fire;

	assign req_op    = req_type_t'(req.req_type);
	assign pos_x     = CMP_W'(req.position);
	assign count_x   = CMP_W'(count_q);
	assign cap_x     = CMP_W'(capacity);
	assign bound_x   = (cap_x < CMP_W'(DEPTH)) ? cap_x : CMP_W'(DEPTH);
	assign full      = (count_x >= bound_x);
	// Positions are only used as write addresses once known to be at most the count.
	assign pos_a     = ADDR_W'(req.position);
	assign count_a   = ADDR_W'(count_q);
	assign last_a    = ADDR_W'(count_q - CNT_W'(1));
	// lo never exceeds hi while a probe is issued, so the sum is non-negative.
	assign mid_c     = (lo_q + hi_q) >>> 1;
	assign mid_inc   = mid_q + SRCH_W'(1);
	assign mid_dec   = mid_q - SRCH_W'(1);

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign res_valid = (state_q == S_DONE);
	assign res       = '{status: status_q, index: idx_q, value: rval_q, count: count_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		ram_raddr = rd_addr_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_op)
						REQ_APPEND: begin
							ram_we    = !full;
							ram_waddr = count_a;
							ram_wdata = req.value;
						end
						REQ_INSERT: begin
							// Insert at the end needs no shift.
							ram_we    = (pos_x == count_x) && !full;
							ram_waddr = pos_a;
							ram_wdata = req.value;
						end
						REQ_READ: begin
							ram_raddr = pos_a;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (vld_s1 && (op_q != REQ_LSEARCH)) begin
					ram_we    = 1'b1;
					ram_waddr = (op_q == REQ_INSERT) ? addr_s1 + ADDR_W'(1)
					                                 : addr_s1 - ADDR_W'(1);
					ram_wdata = ram_rdata;
				end
			end
			S_PUT: begin
				ram_we = 1'b1;
			end
			S_BREAD: begin
				ram_raddr = ADDR_W'(mid_c);
			end
			default: begin
			end
		endcase
	end

	iate_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q  <= S_DONE;
						status_q <= ST_OK;
						case (req_op)
							REQ_APPEND: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							REQ_INSERT: begin
								if (pos_x > count_x) begin
									status_q <= ST_BADPOS;
								end else if (full) begin
									status_q <= ST_FULL;
								end else if (pos_x == count_x) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									rd_addr_q    <= count_a - ADDR_W'(1);
									end_addr_q   <= pos_a;
									issue_done_q <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							REQ_DELETE: begin
								if (pos_x >= count_x) begin
									status_q <= ST_BADPOS;
								end else if (pos_x == count_x - CMP_W'(1)) begin
									count_q <= count_q - CNT_W'(1);
								end else begin
									rd_addr_q    <= pos_a + ADDR_W'(1);
									end_addr_q   <= last_a;
									issue_done_q <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							REQ_READ: begin
								if (pos_x >= count_x) begin
									status_q <= ST_BADPOS;
								end else begin
									state_q <= S_RWAIT;
								end
							end
							REQ_LSEARCH: begin
								if (count_q == '0) begin
									status_q <= ST_NOTFOUND;
								end else begin
									rd_addr_q    <= '0;
									end_addr_q   <= last_a;
									issue_done_q <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							REQ_BSEARCH: begin
								if (count_q == '0) begin
									status_q <= ST_NOTFOUND;
								end else begin
									lo_q    <= '0;
									hi_q    <= SRCH_W'(count_q) - SRCH_W'(1);
									state_q <= S_BREAD;
								end
							end
							default: begin
							end
						endcase
						op_q   <= req_op;
						pos_q  <= pos_a;
						val_q  <= req.value;
						idx_q  <= '0;
						rval_q <= '0;
					end
				end
				S_SCAN: begin
					// One read issued per cycle; its data is handled in the cycle after.
					if (!issue_done_q) begin
						vld_s1  <= 1'b1;
						addr_s1 <= rd_addr_q;
						last_s1 <= (rd_addr_q == end_addr_q);
						if (rd_addr_q == end_addr_q) begin
							issue_done_q <= 1'b1;
						end else if (op_q == REQ_INSERT) begin
							rd_addr_q <= rd_addr_q - ADDR_W'(1);
						end else begin
							rd_addr_q <= rd_addr_q + ADDR_W'(1);
						end
					end
					if (vld_s1) begin
						if (op_q == REQ_LSEARCH) begin
							if (ram_rdata == val_q) begin
								idx_q   <= IDX_W'(addr_s1);
								state_q <= S_DONE;
							end else if (last_s1) begin
								status_q <= ST_NOTFOUND;
								state_q  <= S_DONE;
							end
						end else if (last_s1) begin
							if (op_q == REQ_INSERT) begin
								state_q <= S_PUT;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_DONE;
							end
						end
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_RWAIT: begin
					rval_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_BREAD: begin
					mid_q   <= mid_c;
					state_q <= S_BWAIT;
				end
				S_BWAIT: begin
					if (ram_rdata == val_q) begin
						idx_q   <= IDX_W'(mid_q);
						state_q <= S_DONE;
					end else if ($signed(ram_rdata) < val_q) begin
						lo_q <= mid_inc;
						if (mid_inc > hi_q) begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_BREAD;
						end
					end else begin
						hi_q <= mid_dec;
						if (lo_q > mid_dec) begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_BREAD;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/iate_chk.sv @@
// Port-level checker of the indexed array table engine, bound to the top level.
// Depends on iate_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module iate_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [iate_pkg::ST_W-1:0]           status,
	input wire logic [iate_pkg::IDX_W-1:0]          result_index,
	input wire logic signed [iate_pkg::DATA_W-1:0]  result_value,
	input wire logic [iate_pkg::ENT_W-1:0]          entry_count
);
	import iate_pkg::*;

	// A held result keeps its fields until taken.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(result_index) && $stable(entry_count)
		&& $stable(result_value), "result changed while stalled")

	// Only one item is in work: an accepted item closes the input side.
	`ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while an item is in work")

	// Index and value fields are zero unless the request succeeded.
	`ASSERT_IMPL(a_fail_zero, out_valid && (status != ST_OK),
		(result_index == '0) && (result_value == '0), "failed request reports data")

	// The live count never exceeds the depth.
	`ASSERT_ALWAYS(a_count_max, !out_valid || (int'(entry_count) <= DEPTH), "entry count above depth")

endmodule

bind indexed_array_table_engine iate_chk u_iate_chk (.*);

`default_nettype wire

@@ test/indexed_array_table_engine_test.sv @@
// Self-checking testbench for indexed_array_table_engine: random and directed requests
// are checked against a table model kept inside this file, one result per request.
// Depends on iate_pkg and the engine RTL only.
module indexed_array_table_engine_test;
	import iate_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;
	localparam int LONG_HOLD     = 300;
	localparam int TIMEOUT_TICKS = 10_000_000;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic [REQ_W-1:0]         req_type    = '0;
	logic [POS_W-1:0]         position    = '0;
	logic signed [DATA_W-1:0] value       = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic [ST_W-1:0]          status;
	logic [IDX_W-1:0]         result_index;
	logic signed [DATA_W-1:0] result_value;
	logic [ENT_W-1:0]         entry_count;

	indexed_array_table_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.position     (position),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_index (result_index),
		.result_value (result_value),
		.entry_count  (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Table model: contents, live count and capacity as the engine should hold them.
	logic signed [DATA_W-1:0] shadow_mem [DEPTH];
	int                       shadow_count = 0;
	int                       shadow_cap   = 16;

	req_t request_q [$];
	res_t answers_due [$];
	req_t cur_req;
	int   send_gap   = 0;
	int   recv_gap   = 0;
	int   hold_left  = 0;
	bit   hold_req   = 1'b0;
	bit   idle_on    = 1'b1;
	int   mismatches = 0;

	function automatic res_t table_step(input req_t rq);
		res_t r;
		int   bound;
		int   pos;
		int   i;
		int   lo;
		int   hi;
		int   mid;
		bit   found;
		r.status = ST_OK;
		r.index  = '0;
		r.value  = '0;
		pos      = rq.position;
		bound    = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
		found    = 1'b0;
		case (rq.req_type)
			REQ_APPEND: begin
				if (shadow_count >= bound) begin
					r.status = ST_FULL;
				end else begin
					shadow_mem[shadow_count] = rq.value;
					shadow_count++;
				end
			end
			REQ_INSERT: begin
				// A bad position wins over a full table.
				if (pos > shadow_count) begin
					r.status = ST_BADPOS;
				end else if (shadow_count >= bound) begin
					r.status = ST_FULL;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_mem[i] = shadow_mem[i-1];
					shadow_mem[pos] = rq.value;
					shadow_count++;
				end
			end
			REQ_DELETE: begin
				if (pos >= shadow_count) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_mem[i] = shadow_mem[i+1];
					shadow_count--;
				end
			end
			REQ_READ: begin
				if (pos >= shadow_count)
					r.status = ST_BADPOS;
				else
					r.value = shadow_mem[pos];
			end
			REQ_LSEARCH: begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < shadow_count && !found; i++) begin
					if (shadow_mem[i] == rq.value) begin
						found    = 1'b1;
						r.status = ST_OK;
						r.index  = IDX_W'(i);
					end
				end
			end
			REQ_BSEARCH: begin
				// Plain halving with signed compares; unsorted contents simply miss.
				r.status = ST_NOTFOUND;
				lo       = 0;
				hi       = shadow_count - 1;
				while (lo <= hi && !found) begin
					mid = lo + (hi - lo) / 2;
					if (shadow_mem[mid] == rq.value) begin
						found    = 1'b1;
						r.status = ST_OK;
						r.index  = IDX_W'(mid);
					end else if (shadow_mem[mid] < rq.value) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			default: begin
			end
		endcase
		r.count = CNT_W'(shadow_count);
		return r;
	endfunction

	// Sender: presents queued items and predicts each one as it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				answers_due.push_back(table_step(cur_req));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (request_q.size() > 0) begin
					cur_req = request_q.pop_front();
					in_valid <= 1'b1;
					req_type <= cur_req.req_type;
					position <= cur_req.position;
					value    <= cur_req.value;
					if (idle_on && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 14);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// Receiver: compares each result with the oldest prediction, stalls at random.
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					$display("%0t: result mismatch, expected none, actual status %0d count %0d",
						$time, status, entry_count);
				end else begin
					want = answers_due.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("result_index", DATA_W'(want.index), DATA_W'(result_index));
					check_field("result_value", want.value, result_value);
					check_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 6) == 0)
					recv_gap = $urandom_range(1, 14);
			end
		end
	end

	task automatic push_req(input logic [REQ_W-1:0] kind, input int pos,
			input logic signed [DATA_W-1:0] val);
		req_t rq;
		rq.req_type = kind;
		rq.position = POS_W'(pos);
		rq.value    = val;
		request_q.push_back(rq);
	endtask

	// Half of the values are small so that searches hit and duplicates occur.
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return 32'sh8000_0000;
			3: return 32'sh7FFF_FFFF;
			default: return $urandom_range(0, 16) - 8;
		endcase
	endfunction

	function automatic int rand_pos();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
	endfunction

	task automatic push_random_mix(input int n);
		int k;
		int pick;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 24)
				push_req(REQ_APPEND, rand_pos(), rand_value());
			else if (pick < 44)
				push_req(REQ_INSERT, rand_pos(), rand_value());
			else if (pick < 60)
				push_req(REQ_DELETE, rand_pos(), rand_value());
			else if (pick < 74)
				push_req(REQ_READ, rand_pos(), rand_value());
			else if (pick < 84)
				push_req(REQ_LSEARCH, rand_pos(), rand_value());
			else if (pick < 94)
				push_req(REQ_BSEARCH, rand_pos(), rand_value());
			else
				push_req($urandom_range(0, 1) ? REQ_SPARE7 : REQ_SPARE6, rand_pos(),
					rand_value());
		end
	endtask

	// Empty the table, refill it in ascending order, then probe it.
	task automatic push_sorted_round(input int n_probes);
		logic signed [DATA_W-1:0] keys [DEPTH];
		logic signed [DATA_W-1:0] v;
		int k;
		int pick;
		for (k = 0; k <= DEPTH; k++)
			push_req(REQ_DELETE, 0, rand_value());
		case ($urandom_range(0, 2))
			0: v = 32'sh8000_0000;
			1: v = 32'sh7FFF_FFFF - 700;
			default: v = $urandom_range(0, 400) - 200;
		endcase
		for (k = 0; k < DEPTH; k++) begin
			push_req(REQ_APPEND, rand_pos(), v);
			keys[k] = v;
			v = v + $urandom_range(0, 40);
		end
		for (k = 0; k < n_probes; k++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				push_req(REQ_BSEARCH, rand_pos(), keys[$urandom_range(0, DEPTH-1)]);
			else if (pick == 6)
				push_req(REQ_BSEARCH, rand_pos(), keys[$urandom_range(0, DEPTH-1)] + 1);
			else if (pick == 7)
				push_req(REQ_LSEARCH, rand_pos(), keys[$urandom_range(0, DEPTH-1)]);
			else if (pick == 8)
				push_req(REQ_READ, rand_pos(), rand_value());
			else
				push_random_mix(1);
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_q.size() != 0 || in_valid || answers_due.size() != 0);
	endtask

	// The register may only change with nothing in flight.
	task automatic write_capacity(input int cap);
		wait_idle();
		repeat (6) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CAP_W'(cap);
		shadow_cap = cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int cap_plan [14];
		int ph;
		cap_plan = '{16, 0, 31, 1, 8, 15, 17, 2, 10, 16, 5, 31, 12, 16};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, then edge words, edge positions and every request code.
		push_req(REQ_READ, 0, 0);
		push_req(REQ_DELETE, 0, 0);
		push_req(REQ_LSEARCH, 0, 0);
		push_req(REQ_BSEARCH, 0, 0);
		push_req(REQ_INSERT, 1, 7);
		push_req(REQ_APPEND, 0, 32'sh8000_0000);
		push_req(REQ_APPEND, 31, 32'sh7FFF_FFFF);
		push_req(REQ_INSERT, 0, 0);
		push_req(REQ_INSERT, 3, -1);
		push_req(REQ_INSERT, 31, 9);
		push_req(REQ_READ, 31, 0);
		push_req(REQ_READ, 3, 0);
		push_req(REQ_DELETE, 4, 0);
		push_req(REQ_LSEARCH, 0, 32'sh7FFF_FFFF);
		push_req(REQ_BSEARCH, 0, -1);
		push_req(REQ_LSEARCH, 0, 12345);
		push_req(REQ_SPARE6, 0, 0);
		push_req(REQ_SPARE7, 31, -1);
		push_req(REQ_DELETE, 0, 0);
		push_req(REQ_DELETE, 2, 0);
		push_req(REQ_BSEARCH, 0, 32'sh8000_0000);
		push_req(REQ_BSEARCH, 0, 32'sh7FFF_FFFF);
		push_req(REQ_READ, 1, 0);
		// Count now sits at the bound, then above it.
		write_capacity(2);
		push_req(REQ_APPEND, 0, 3);
		push_req(REQ_INSERT, 0, 3);
		push_req(REQ_INSERT, 3, 3);
		write_capacity(0);
		push_req(REQ_APPEND, 0, 4);
		push_req(REQ_READ, 0, 0);

		for (ph = 0; ph < 14; ph++) begin
			write_capacity(cap_plan[ph]);
			if (ph >= 12)
				idle_on = 1'b0;
			if (ph % 2 == 0)
				push_random_mix(140);
			else
				push_sorted_round(80);
			// Block the result side while requests keep coming.
			if (ph == 3)
				hold_req = 1'b1;
			if (ph == 5) begin
				wait_idle();
				push_random_mix(40);
			end
			wait_idle();
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_TICKS);
		$display("%0t: timeout", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ indexed_array_table_engine.f @@
+incdir+sv
sv/iate_pkg.sv
sv/iate_ram.sv
sv/iate_seq.sv
sv/indexed_array_table_engine.sv
sv/iate_chk.sv
test/indexed_array_table_engine_test.sv
